### rtl/dltq_pkg.sv
// Package for the delta-list timeout queue.
// Holds sizes, command and result codes, the list entry type and the cell operations.
// Used by dltq_cell and delta_list_timeout_queue.
package dltq_pkg;

	localparam int DEPTH   = 16;
	localparam int DELAY_W = 32;
	localparam int ID_W    = 8;
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	typedef enum logic [1:0] {
		CMD_ADVANCE = 2'd0,
		CMD_INSERT  = 2'd1,
		CMD_CANCEL  = 2'd2,
		CMD_NONE    = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_EXPIRED = 2'd0,
		KIND_REPORT  = 2'd1,
		KIND_INSERT  = 2'd2,
		KIND_CANCEL  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_FULL      = 2'd1,
		STATUS_NOT_FOUND = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		CELL_HOLD      = 3'd0,
		CELL_LOAD      = 3'd1,
		CELL_LEFT      = 3'd2,
		CELL_LEFT_SUB  = 3'd3,
		CELL_RIGHT     = 3'd4,
		CELL_RIGHT_ADD = 3'd5,
		CELL_SUB       = 3'd6
	} cell_op_t;

	typedef struct packed {
		logic [ID_W-1:0]    id;
		logic [DELAY_W-1:0] delta;
	} entry_t;

	typedef struct packed {
		kind_t              kind;
		logic [ID_W-1:0]    expired_id;
		logic [DELAY_W-1:0] next_delay;
		logic               has_next;
		status_t            status;
		logic               last;
	} result_t;

endpackage

### rtl/delta_list_timeout_queue.sv
// Top level of the delta-list timeout queue: command control and the chain of cells.
// Depends on dltq_pkg and dltq_cell.
//
// An advance gives one result for each expired entry and then the report, and each
// result appears on the cycle after the entry is examined. An insert walks the list one
// cell per cycle, and a cancel walks it likewise. An insert into a full list answers
// at once without raising busy. Results are shown for one cycle with strobe high and
// cannot be held off; last marks the final result of an item. The next item may be
// started once busy is low.
module delta_list_timeout_queue (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic [1:0]                   command,
	input  logic [dltq_pkg::ID_W-1:0]    timer_id,
	input  logic [dltq_pkg::DELAY_W-1:0] delay,
	input  logic [dltq_pkg::DELAY_W-1:0] elapsed,
	output logic                         strobe,
	output logic [1:0]                   kind,
	output logic [dltq_pkg::ID_W-1:0]    expired_id,
	output logic [dltq_pkg::DELAY_W-1:0] next_delay,
	output logic                         has_next,
	output logic [1:0]                   status,
	output logic                         last
);
	import dltq_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_ADV  = 4'b0010,
		ST_INS  = 4'b0100,
		ST_CAN  = 4'b1000
	} state_t;

	state_t             state_q, state_nxt;
	logic [CNT_W-1:0]   count_q, count_nxt;
	logic [CNT_W-1:0]   idx_q, idx_nxt;
	logic [DELAY_W-1:0] rem_q, rem_nxt;
	logic [DELAY_W-1:0] clk_q, clk_nxt;
	logic [ID_W-1:0]    id_q;
	logic               strobe_q, res_valid;
	result_t            result_q, res;

	entry_t             cells [DEPTH];
	cell_op_t           ops [DEPTH];
	entry_t             head, cur, load;
	logic [DELAY_W-1:0] arg;
	logic               accept, list_empty, idx_in_list;
	logic               adv_expire, ins_step, can_hit;

	assign busy        = (state_q != ST_IDLE);
	assign accept      = start && !busy;
	assign head        = cells[0];
	assign cur         = cells[idx_q[IDX_W-1:0]];
	assign list_empty  = (count_q == '0);
	assign idx_in_list = (idx_q < count_q);
	assign adv_expire  = (state_q == ST_ADV) && !list_empty && (clk_q >= head.delta);
	assign ins_step    = (state_q == ST_INS) && idx_in_list && (rem_q >= cur.delta);
	assign can_hit     = (state_q == ST_CAN) && idx_in_list && (cur.id == id_q);
	assign load        = '{id: id_q, delta: rem_q};
	assign arg         = (state_q == ST_ADV) ? clk_q : rem_q;

	always_comb begin
		for (int j = 0; j < DEPTH; j++) begin
			ops[j] = CELL_HOLD;
			case (state_q)
				ST_ADV: begin
					if (adv_expire)
						ops[j] = CELL_RIGHT;
					else if (j == 0 && !list_empty)
						ops[j] = CELL_SUB;
				end
				ST_INS: begin
					if (!ins_step) begin
						if (CNT_W'(j) == idx_q)
							ops[j] = CELL_LOAD;
						else if (CNT_W'(j) == idx_q + CNT_W'(1))
							ops[j] = CELL_LEFT_SUB;
						else if (CNT_W'(j) > idx_q)
							ops[j] = CELL_LEFT;
					end
				end
				ST_CAN: begin
					if (can_hit) begin
						if (CNT_W'(j) == idx_q)
							ops[j] = CELL_RIGHT_ADD;
						else if (CNT_W'(j) > idx_q)
							ops[j] = CELL_RIGHT;
					end
				end
				default: ops[j] = CELL_HOLD;
			endcase
		end
	end

	for (genvar g = 0; g < DEPTH; g++) begin : g_cell
		dltq_cell u_cell (
			.clk   (clk),
			.op    (ops[g]),
			.left  ((g == 0) ? load : cells[(g == 0) ? 0 : g - 1]),
			.right ((g == DEPTH - 1) ? cells[g] : cells[(g == DEPTH - 1) ? g : g + 1]),
			.load  (load),
			.arg   (arg),
			.data  (cells[g])
		);
	end

	always_comb begin
		state_nxt = state_q;
		count_nxt = count_q;
		idx_nxt   = idx_q;
		rem_nxt   = rem_q;
		clk_nxt   = clk_q;
		res_valid = 1'b0;
		res       = '{kind: KIND_REPORT, expired_id: '0, next_delay: '0,
		              has_next: 1'b0, status: STATUS_OK, last: 1'b1};
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_nxt = '0;
					rem_nxt = delay;
					clk_nxt = elapsed;
					case (cmd_t'(command))
						CMD_ADVANCE: state_nxt = ST_ADV;
						CMD_INSERT: begin
							if (count_q == CNT_W'(DEPTH)) begin
								res_valid  = 1'b1;
								res.kind   = KIND_INSERT;
								res.status = STATUS_FULL;
							end else begin
								state_nxt = ST_INS;
							end
						end
						CMD_CANCEL: state_nxt = ST_CAN;
						default:    state_nxt = ST_IDLE;
					endcase
				end
			end
			ST_ADV: begin
				res_valid = 1'b1;
				if (adv_expire) begin
					clk_nxt        = clk_q - head.delta;
					count_nxt      = count_q - CNT_W'(1);
					res.kind       = KIND_EXPIRED;
					res.expired_id = head.id;
					res.last       = 1'b0;
				end else begin
					state_nxt = ST_IDLE;
					if (!list_empty) begin
						res.next_delay = head.delta - clk_q;
						res.has_next   = 1'b1;
					end
				end
			end
			ST_INS: begin
				if (ins_step) begin
					rem_nxt = rem_q - cur.delta;
					idx_nxt = idx_q + CNT_W'(1);
				end else begin
					count_nxt = count_q + CNT_W'(1);
					state_nxt = ST_IDLE;
					res_valid = 1'b1;
					res.kind  = KIND_INSERT;
				end
			end
			ST_CAN: begin
				if (can_hit) begin
					count_nxt = count_q - CNT_W'(1);
					state_nxt = ST_IDLE;
					res_valid = 1'b1;
					res.kind  = KIND_CANCEL;
				end else if (idx_in_list) begin
					idx_nxt = idx_q + CNT_W'(1);
				end else begin
					state_nxt  = ST_IDLE;
					res_valid  = 1'b1;
					res.kind   = KIND_CANCEL;
					res.status = STATUS_NOT_FOUND;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= '0;
			strobe_q <= 1'b0;
		end else begin
			state_q  <= state_nxt;
			count_q  <= count_nxt;
			strobe_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		idx_q    <= idx_nxt;
		rem_q    <= rem_nxt;
		clk_q    <= clk_nxt;
		result_q <= res;
		if (accept)
			id_q <= timer_id;
	end

	assign strobe     = strobe_q;
	assign kind       = result_q.kind;
	assign expired_id = result_q.expired_id;
	assign next_delay = result_q.next_delay;
	assign has_next   = result_q.has_next;
	assign status     = result_q.status;
	assign last       = result_q.last;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("entry count exceeds the list depth");

	a_answer_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (kind == KIND_INSERT || kind == KIND_CANCEL || kind == KIND_REPORT) |-> last)
		else $error("single answer not marked last");

	a_fell_busy: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> strobe && last)
		else $error("command finished without a final result");

	a_expire_count: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && kind == KIND_EXPIRED |-> count_q == $past(count_q) - CNT_W'(1))
		else $error("expired item did not remove an entry");

endmodule

### rtl/dltq_cell.sv
// One cell of the delta-list chain: holds one entry and its relative delay.
// Takes its neighbor's entry when the list shifts. Depends on dltq_pkg.
module dltq_cell (
	input  logic                        clk,
	input  dltq_pkg::cell_op_t          op,
	input  dltq_pkg::entry_t            left,
	input  dltq_pkg::entry_t            right,
	input  dltq_pkg::entry_t            load,
	input  logic [dltq_pkg::DELAY_W-1:0] arg,
	output dltq_pkg::entry_t            data
);
	import dltq_pkg::*;

	entry_t data_q;
	entry_t data_nxt;

	always_comb begin
		case (op)
			CELL_HOLD:      data_nxt = data_q;
			CELL_LOAD:      data_nxt = load;
			CELL_LEFT:      data_nxt = left;
			CELL_LEFT_SUB:  data_nxt = '{id: left.id, delta: left.delta - arg};
			CELL_RIGHT:     data_nxt = right;
			CELL_RIGHT_ADD: data_nxt = '{id: right.id, delta: right.delta + data_q.delta};
			CELL_SUB:       data_nxt = '{id: data_q.id, delta: data_q.delta - arg};
			default:        data_nxt = data_q;
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;

endmodule
